// ===== hdl/date_difference_days_core_assert.svh =====
// Assertion macros for the date difference core and its checker.
// Every macro samples on clk and is disabled while rst_n is low.
`ifndef DATE_DIFFERENCE_DAYS_CORE_ASSERT_SVH
`define DATE_DIFFERENCE_DAYS_CORE_ASSERT_SVH

// Condition must hold at every sampled edge.
`define DDD_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define DDD_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== hdl/ddd_pkg.sv =====
// Shared types, constants and lookup functions for the date difference core.
// No dependencies; used by the core and by its checker.
package ddd_pkg;

  // Field widths
  localparam int DAY_W   = 5;
  localparam int MONTH_W = 4;
  localparam int YEAR_W  = 14;
  localparam int ORD_W   = 9;
  localparam int DIST_W  = 22;
  // Day number since the epoch, wide enough for any 14-bit year
  localparam int TOT_W   = 23;

  // Year split for the divide-by-25 reciprocal
  localparam int YQ_W     = YEAR_W - 2;   // year / 4
  localparam int Y16_W    = YEAR_W - 4;   // year / 16
  localparam int RECIP_W  = 13;
  localparam int PRODQ_W  = YQ_W + RECIP_W;
  localparam int PROD16_W = Y16_W + RECIP_W;
  localparam int QUO_SH   = 17;
  localparam int Q100_W   = PRODQ_W - QUO_SH;
  localparam int Q400_W   = PROD16_W - QUO_SH;

  // floor(x * 5243 / 2^17) == floor(x / 25) for x below 4096
  localparam logic [RECIP_W-1:0] RECIP_25  = 13'd5243;
  localparam logic [ORD_W-1:0]   DAYS_YEAR = 9'd365;
  localparam logic [YEAR_W-1:0]  YEAR_MAX  = 14'd9999;
  localparam logic [DIST_W-1:0]  DIST_MAX  = 22'd3652058;
  localparam logic [ORD_W-1:0]   ORD_MAX   = 9'd366;

  localparam logic [MONTH_W-1:0] MON_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MON_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MON_DEC = 4'd12;

  typedef struct packed {
    logic [DAY_W-1:0]   day_a;
    logic [MONTH_W-1:0] month_a;
    logic [YEAR_W-1:0]  year_a;
    logic [DAY_W-1:0]   day_b;
    logic [MONTH_W-1:0] month_b;
    logic [YEAR_W-1:0]  year_b;
  } in_req_t;

  typedef struct packed {
    logic               valid_a;
    logic               valid_b;
    logic [ORD_W-1:0]   ordinal_a;
    logic [ORD_W-1:0]   ordinal_b;
    logic [DIST_W-1:0]  distance;
  } out_res_t;

  // Days before the first of the month, common year
  function automatic logic [ORD_W-1:0] days_before_month(input logic [MONTH_W-1:0] m);
    logic [ORD_W-1:0] r;
    unique case (m)
      4'd1:    r = 9'd0;
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  // Month length; February gets its leap day from the caller
  function automatic logic [DAY_W-1:0] month_length(input logic [MONTH_W-1:0] m,
                                                    input logic leap);
    logic [DAY_W-1:0] r;
    unique case (m)
      4'd2:                   r = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: r = 5'd30;
      default:                r = 5'd31;
    endcase
    return r;
  endfunction

  // 25 * q by shift and add
  function automatic logic [YQ_W-1:0] times25(input logic [Q100_W-1:0] q);
    logic [YQ_W-1:0] x;
    x = {{(YQ_W-Q100_W){1'b0}}, q};
    return (x << 4) + (x << 3) + x;
  endfunction

endpackage

// ===== hdl/date_difference_days_core.sv =====
// Gregorian date difference core: validity, day of year and day distance.
// Depends on ddd_pkg.
//
//  channel  | ports                      | handshake
//  ---------+----------------------------+--------------------------------
//  request  | start, busy, in_req        | taken when start && !busy
//  result   | out_strobe, out_res        | one-cycle strobe, cannot stall
//
// Five register stages; one request per cycle. The result strobe and the result
// are both registered in the fifth stage. Stages in order: reciprocal multiplies,
// leap test and year days, ordinal and epoch sum, total, abs diff.
// busy is high only while rst_n is low; reset clears the stage valid bits.
// No stalls: the receiver takes every result, so requests never back up.
module date_difference_days_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  ddd_pkg::in_req_t  in_req,
  output logic              out_strobe,
  output ddd_pkg::out_res_t out_res
);

  typedef struct packed {
    logic [ddd_pkg::DAY_W-1:0]    day;
    logic [ddd_pkg::MONTH_W-1:0]  month;
    logic [3:0]                   y_lo;
    logic [ddd_pkg::YQ_W-1:0]     yq;
    logic                         y_ok;
    logic [ddd_pkg::PRODQ_W-1:0]  yq_prod;
    logic [ddd_pkg::PROD16_W-1:0] y16_prod;
    logic [ddd_pkg::YEAR_W-1:0]   p;
    logic [ddd_pkg::PRODQ_W-1:0]  pq_prod;
    logic [ddd_pkg::PROD16_W-1:0] p16_prod;
  } s1_t;

  typedef struct packed {
    logic                        valid;
    logic                        leap_add;
    logic [ddd_pkg::ORD_W-1:0]   dbm;
    logic [ddd_pkg::DAY_W-1:0]   day;
    logic [ddd_pkg::TOT_W-1:0]   p365;
    logic [ddd_pkg::YQ_W-1:0]    p4;
    logic [ddd_pkg::Q100_W-1:0]  p100;
    logic [ddd_pkg::Q400_W-1:0]  p400;
  } s2_t;

  typedef struct packed {
    logic                      valid;
    logic [ddd_pkg::ORD_W-1:0] ord;
    logic [ddd_pkg::TOT_W-1:0] days;
  } s3_t;

  logic [ddd_pkg::DAY_W-1:0]   day_in   [2];
  logic [ddd_pkg::MONTH_W-1:0] month_in [2];
  logic [ddd_pkg::YEAR_W-1:0]  year_in  [2];

  s1_t s1_nxt [2];
  s1_t s1_r   [2];
  s2_t s2_nxt [2];
  s2_t s2_r   [2];
  s3_t s3_nxt [2];
  s3_t s3_r   [2];
  s3_t s4_nxt [2];
  s3_t s4_r   [2];

  logic [3:0]        vld_r;
  logic [3:0]        vld_nxt;
  logic              out_strobe_r;
  ddd_pkg::out_res_t out_res_nxt;
  ddd_pkg::out_res_t out_res_r;

  logic accept;

  assign busy   = ~rst_n;
  assign accept = start & ~busy;

  // Lane 0 is the first date, lane 1 the second
  assign day_in[0]   = in_req.day_a;
  assign month_in[0] = in_req.month_a;
  assign year_in[0]  = in_req.year_a;
  assign day_in[1]   = in_req.day_b;
  assign month_in[1] = in_req.month_b;
  assign year_in[1]  = in_req.year_b;

  // Stage 1: range check, year - 1, reciprocal products for /100 and /400
  always_comb begin
    logic [ddd_pkg::YEAR_W-1:0] p;
    for (int i = 0; i < 2; i++) begin
      p = year_in[i] - {{(ddd_pkg::YEAR_W-1){1'b0}}, 1'b1};
      s1_nxt[i].day      = day_in[i];
      s1_nxt[i].month    = month_in[i];
      s1_nxt[i].y_lo     = year_in[i][3:0];
      s1_nxt[i].yq       = year_in[i][ddd_pkg::YEAR_W-1:2];
      s1_nxt[i].y_ok     = (year_in[i] != '0) && (year_in[i] <= ddd_pkg::YEAR_MAX);
      s1_nxt[i].p        = p;
      s1_nxt[i].yq_prod  = {{ddd_pkg::RECIP_W{1'b0}}, year_in[i][ddd_pkg::YEAR_W-1:2]}
                         * {{ddd_pkg::YQ_W{1'b0}}, ddd_pkg::RECIP_25};
      s1_nxt[i].y16_prod = {{ddd_pkg::RECIP_W{1'b0}}, year_in[i][ddd_pkg::YEAR_W-1:4]}
                         * {{ddd_pkg::Y16_W{1'b0}}, ddd_pkg::RECIP_25};
      s1_nxt[i].pq_prod  = {{ddd_pkg::RECIP_W{1'b0}}, p[ddd_pkg::YEAR_W-1:2]}
                         * {{ddd_pkg::YQ_W{1'b0}}, ddd_pkg::RECIP_25};
      s1_nxt[i].p16_prod = {{ddd_pkg::RECIP_W{1'b0}}, p[ddd_pkg::YEAR_W-1:4]}
                         * {{ddd_pkg::Y16_W{1'b0}}, ddd_pkg::RECIP_25};
    end
  end

  // Stage 2: leap test, date validity, month offset, 365 * (year - 1)
  always_comb begin
    logic [ddd_pkg::Q100_W-1:0] q100;
    logic [ddd_pkg::Q400_W-1:0] q400;
    logic                       div100;
    logic                       div400;
    logic                       leap;
    logic                       m_ok;
    logic [ddd_pkg::DAY_W-1:0]  len;
    for (int i = 0; i < 2; i++) begin
      q100   = s1_r[i].yq_prod[ddd_pkg::PRODQ_W-1:ddd_pkg::QUO_SH];
      q400   = s1_r[i].y16_prod[ddd_pkg::PROD16_W-1:ddd_pkg::QUO_SH];
      div100 = (s1_r[i].y_lo[1:0] == 2'b00) && (ddd_pkg::times25(q100) == s1_r[i].yq);
      div400 = (s1_r[i].y_lo == 4'b0000)
            && (ddd_pkg::times25({{(ddd_pkg::Q100_W-ddd_pkg::Q400_W){1'b0}}, q400})
                == {2'b00, s1_r[i].yq[ddd_pkg::YQ_W-1:2]});
      leap   = ((s1_r[i].y_lo[1:0] == 2'b00) && !div100) || div400;
      m_ok   = (s1_r[i].month >= ddd_pkg::MON_JAN) && (s1_r[i].month <= ddd_pkg::MON_DEC);
      len    = ddd_pkg::month_length(s1_r[i].month, leap);
      s2_nxt[i].valid    = s1_r[i].y_ok && m_ok && (s1_r[i].day != '0)
                        && (s1_r[i].day <= len);
      s2_nxt[i].leap_add = leap && (s1_r[i].month > ddd_pkg::MON_FEB);
      s2_nxt[i].dbm      = ddd_pkg::days_before_month(s1_r[i].month);
      s2_nxt[i].day      = s1_r[i].day;
      s2_nxt[i].p365     = {{(ddd_pkg::TOT_W-ddd_pkg::YEAR_W){1'b0}}, s1_r[i].p}
                        * {{(ddd_pkg::TOT_W-ddd_pkg::ORD_W){1'b0}}, ddd_pkg::DAYS_YEAR};
      s2_nxt[i].p4       = s1_r[i].p[ddd_pkg::YEAR_W-1:2];
      s2_nxt[i].p100     = s1_r[i].pq_prod[ddd_pkg::PRODQ_W-1:ddd_pkg::QUO_SH];
      s2_nxt[i].p400     = s1_r[i].p16_prod[ddd_pkg::PROD16_W-1:ddd_pkg::QUO_SH];
    end
  end

  // Stage 3: day of year and days before the year
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      s3_nxt[i].valid = s2_r[i].valid;
      s3_nxt[i].ord   = s2_r[i].valid
                      ? (s2_r[i].dbm
                         + {{(ddd_pkg::ORD_W-ddd_pkg::DAY_W){1'b0}}, s2_r[i].day}
                         + {{(ddd_pkg::ORD_W-1){1'b0}}, s2_r[i].leap_add})
                      : '0;
      s3_nxt[i].days  = s2_r[i].p365
                      + {{(ddd_pkg::TOT_W-ddd_pkg::YQ_W){1'b0}}, s2_r[i].p4}
                      - {{(ddd_pkg::TOT_W-ddd_pkg::Q100_W){1'b0}}, s2_r[i].p100}
                      + {{(ddd_pkg::TOT_W-ddd_pkg::Q400_W){1'b0}}, s2_r[i].p400};
    end
  end

  // Stage 4: day number of each date
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      s4_nxt[i].valid = s3_r[i].valid;
      s4_nxt[i].ord   = s3_r[i].ord;
      s4_nxt[i].days  = s3_r[i].days
                      + {{(ddd_pkg::TOT_W-ddd_pkg::ORD_W){1'b0}}, s3_r[i].ord};
    end
  end

  // Stage 5: absolute difference, zero unless both dates exist
  always_comb begin
    logic [ddd_pkg::TOT_W-1:0] diff;
    diff = (s4_r[0].days >= s4_r[1].days) ? (s4_r[0].days - s4_r[1].days)
                                          : (s4_r[1].days - s4_r[0].days);
    out_res_nxt.valid_a   = s4_r[0].valid;
    out_res_nxt.valid_b   = s4_r[1].valid;
    out_res_nxt.ordinal_a = s4_r[0].ord;
    out_res_nxt.ordinal_b = s4_r[1].ord;
    out_res_nxt.distance  = (s4_r[0].valid && s4_r[1].valid)
                          ? diff[ddd_pkg::DIST_W-1:0] : '0;
  end

  // Valid bits travel with the stages
  assign vld_nxt = {vld_r[2:0], accept};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r        <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      vld_r        <= vld_nxt;
      out_strobe_r <= vld_r[3];
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk) begin
    s1_r      <= s1_nxt;
    s2_r      <= s2_nxt;
    s3_r      <= s3_nxt;
    s4_r      <= s4_nxt;
    out_res_r <= out_res_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_res    = out_res_r;

endmodule

// ===== hdl/ddd_checker.sv =====
// Port-level checker for the date difference core, bound into the core module.
// Depends on ddd_pkg and date_difference_days_core_assert.svh.
`include "date_difference_days_core_assert.svh"

module ddd_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input ddd_pkg::in_req_t  in_req,
  input logic              out_strobe,
  input ddd_pkg::out_res_t out_res
);

  // The core never refuses a request outside reset
  `DDD_ASSERT_ALWAYS(a_no_busy, !busy, "busy high outside reset")

  // Result strobe in step: each strobe answers the request accepted as it entered
  // the stage chain, checked only once every stage was loaded out of reset
  `DDD_ASSERT_IMPLY(a_latency, $past(rst_n, 1) && $past(rst_n, 2) && $past(rst_n, 3) && $past(rst_n, 4) && $past(rst_n, 5), out_strobe == $past(start && !busy, 5), "result strobe out of step")

  // An invalid date has ordinal zero and forces distance zero
  `DDD_ASSERT_IMPLY(a_invalid_zero, out_strobe && !(out_res.valid_a && out_res.valid_b), out_res.distance == '0 && (out_res.valid_a || out_res.ordinal_a == '0) && (out_res.valid_b || out_res.ordinal_b == '0), "invalid date with nonzero result")

  // A valid date has an ordinal in 1..366 and distance stays in range
  `DDD_ASSERT_IMPLY(a_valid_range, out_strobe, (!out_res.valid_a || (out_res.ordinal_a != '0 && out_res.ordinal_a <= ddd_pkg::ORD_MAX)) && (!out_res.valid_b || (out_res.ordinal_b != '0 && out_res.ordinal_b <= ddd_pkg::ORD_MAX)) && out_res.distance <= ddd_pkg::DIST_MAX, "result out of range")

endmodule

bind date_difference_days_core ddd_checker u_ddd_checker (.*);

// ===== dv/date_difference_days_checker.sv =====
// Checker for date_difference_days_core: watches the request and result ports,
// predicts each result from the request and compares it field by field.
// Depends on ddd_pkg for the port structs, field widths and YEAR_MAX.
module date_difference_days_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              busy,
  input  ddd_pkg::in_req_t  in_req,
  input  logic              out_strobe,
  input  ddd_pkg::out_res_t out_res,
  output int unsigned       pending,
  output int unsigned       error_count
);
  timeunit 1ns;
  timeprecision 1ps;

  import ddd_pkg::*;

  localparam int unsigned MONTHS_PER_YEAR = 12;

  // request kept beside its predicted result for error messages
  typedef struct packed {
    in_req_t  req;
    out_res_t res;
  } date_check_t;

  date_check_t expected_q[$];
  int unsigned result_no;

  // Gregorian rule, including the every-400-years exception
  function automatic bit leap_year(input int unsigned y);
    return ((y % 4) == 0 && (y % 100) != 0) || ((y % 400) == 0);
  endfunction

  function automatic int unsigned month_span(input int unsigned m, input bit leap);
    int unsigned n;
    case (m)
      32'(MON_FEB):  n = leap ? 29 : 28;
      4, 6, 9, 11:   n = 30;
      default:       n = 31;
    endcase
    return n;
  endfunction

  function automatic bit date_exists(input int unsigned d, input int unsigned m,
                                     input int unsigned y);
    if (y < 1 || y > 32'(YEAR_MAX)) return 1'b0;
    if (m < 1 || m > MONTHS_PER_YEAR) return 1'b0;
    return d >= 1 && d <= month_span(m, leap_year(y));
  endfunction

  // day of year: whole earlier months plus the day itself
  function automatic int unsigned day_in_year(input int unsigned d, input int unsigned m,
                                              input int unsigned y);
    int unsigned n;
    n = d;
    for (int unsigned k = 1; k < m; k++) n += month_span(k, leap_year(y));
    return n;
  endfunction

  // days before 1 January of year y, counted from 1 January of year 1
  function automatic int unsigned days_to_year(input int unsigned y);
    int unsigned p;
    p = y - 1;
    return p * 365 + p / 4 - p / 100 + p / 400;
  endfunction

  function automatic out_res_t predict_dates(input in_req_t r);
    out_res_t    res;
    bit          ok_a, ok_b;
    int unsigned da, ma, ya, db, mb, yb;
    int unsigned ord_a, ord_b, abs_a, abs_b;
    da    = 32'(r.day_a);
    ma    = 32'(r.month_a);
    ya    = 32'(r.year_a);
    db    = 32'(r.day_b);
    mb    = 32'(r.month_b);
    yb    = 32'(r.year_b);
    ok_a  = date_exists(da, ma, ya);
    ok_b  = date_exists(db, mb, yb);
    ord_a = ok_a ? day_in_year(da, ma, ya) : 0;
    ord_b = ok_b ? day_in_year(db, mb, yb) : 0;
    res.valid_a   = ok_a;
    res.valid_b   = ok_b;
    res.ordinal_a = ord_a[ORD_W-1:0];
    res.ordinal_b = ord_b[ORD_W-1:0];
    res.distance  = '0;
    if (ok_a && ok_b) begin
      abs_a = days_to_year(ya) + ord_a;
      abs_b = days_to_year(yb) + ord_b;
      res.distance = (abs_a >= abs_b) ? DIST_W'(abs_a - abs_b) : DIST_W'(abs_b - abs_a);
    end
    return res;
  endfunction

  task automatic flag_error(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want, input in_req_t r);
    if (got !== want)
      flag_error($sformatf("result %0d %s: got %0d expected %0d (a=%0d/%0d/%0d b=%0d/%0d/%0d)",
                           result_no, name, got, want, r.day_a, r.month_a, r.year_a,
                           r.day_b, r.month_b, r.year_b));
  endtask

  // results are checked before the request of the same edge is queued;
  // the pipeline never returns a request on the edge that takes it
  always @(posedge clk) begin : monitor
    date_check_t head;
    date_check_t entry;
    if (rst_n && out_strobe) begin
      if (expected_q.size() == 0) begin
        flag_error($sformatf("result %0d arrived with no request waiting: %h",
                             result_no, out_res));
      end else begin
        head = expected_q.pop_front();
        check_field("valid_a",   32'(out_res.valid_a),   32'(head.res.valid_a),   head.req);
        check_field("valid_b",   32'(out_res.valid_b),   32'(head.res.valid_b),   head.req);
        check_field("ordinal_a", 32'(out_res.ordinal_a), 32'(head.res.ordinal_a), head.req);
        check_field("ordinal_b", 32'(out_res.ordinal_b), 32'(head.res.ordinal_b), head.req);
        check_field("distance",  32'(out_res.distance),  32'(head.res.distance),  head.req);
      end
      result_no++;
    end
    if (rst_n && start && !busy) begin
      entry.req = in_req;
      entry.res = predict_dates(in_req);
      expected_q.push_back(entry);
    end
    pending <= expected_q.size();
  end

endmodule

// ===== dv/testbench.sv =====
// Top of the date difference testbench: clock, reset, request stimulus,
// watchdog and verdict. Depends on ddd_pkg, date_difference_days_core and
// date_difference_days_checker.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ddd_pkg::*;

  localparam int unsigned RANDOM_ITEMS   = 850;
  localparam int unsigned TAIL_ITEMS     = 120;  // last requests go back to back
  localparam int unsigned WATCHDOG_LIMIT = 200;
  localparam int unsigned DRAIN_LIMIT    = 100;
  localparam int unsigned SETTLE_CYCLES  = 10;
  localparam logic [YEAR_W-1:0] YEAR_TOP = '1;

  typedef struct packed {
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
  } cal_date_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  in_req_t     in_req = '0;
  logic        out_strobe;
  out_res_t    out_res;
  int unsigned pending;
  int unsigned error_count;
  int unsigned idle_cycles = 0;

  date_difference_days_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_req     (in_req),
    .out_strobe (out_strobe),
    .out_res    (out_res)
  );

  date_difference_days_checker checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_req      (in_req),
    .out_strobe  (out_strobe),
    .out_res     (out_res),
    .pending     (pending),
    .error_count (error_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // watchdog: ends the run after too many cycles with no request or result
  always @(posedge clk) begin
    if (rst_n && ((start && !busy) || out_strobe)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: %0d cycles without a request or result", idle_cycles);
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic in_req_t date_pair(input logic [DAY_W-1:0] da,
                                        input logic [MONTH_W-1:0] ma,
                                        input logic [YEAR_W-1:0] ya,
                                        input logic [DAY_W-1:0] db,
                                        input logic [MONTH_W-1:0] mb,
                                        input logic [YEAR_W-1:0] yb);
    in_req_t r;
    r.day_a = da;  r.month_a = ma;  r.year_a = ya;
    r.day_b = db;  r.month_b = mb;  r.year_b = yb;
    return r;
  endfunction

  // mostly plausible dates, weighted toward century years and year edges
  function automatic cal_date_t random_date();
    cal_date_t c;
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 6)       c.year = YEAR_W'($urandom_range(1, YEAR_MAX));
    else if (sel < 8)  c.year = YEAR_W'($urandom_range(1, 99) * 100
                                        + $urandom_range(0, 2) - 1);
    else if (sel == 8) c.year = YEAR_W'($urandom_range(1, 10));
    else               c.year = YEAR_W'($urandom_range(int'(YEAR_MAX) - 9, YEAR_MAX));
    if ($urandom_range(0, 9) == 0) begin
      // month boundaries: end of February, turn of the year
      case ($urandom_range(0, 2))
        0:       begin c.month = MON_FEB; c.day = DAY_W'($urandom_range(28, 29)); end
        1:       begin c.month = MON_DEC; c.day = DAY_W'(31); end
        default: begin c.month = MON_JAN; c.day = DAY_W'(1); end
      endcase
    end else begin
      c.month = MONTH_W'($urandom_range(MON_JAN, MON_DEC));
      c.day   = ($urandom_range(0, 3) != 0) ? DAY_W'($urandom_range(1, 28))
                                            : DAY_W'($urandom_range(29, 31));
    end
    return c;
  endfunction

  // breaks one field of a date, or replaces it with raw bits
  function automatic cal_date_t broken_date(input cal_date_t c);
    cal_date_t   r;
    logic [31:0] raw;
    r   = c;
    raw = $urandom;
    case ($urandom_range(0, 5))
      0:       r.day   = '0;
      1:       r.month = '0;
      2:       r.month = MONTH_W'($urandom_range(int'(MON_DEC) + 1, (1 << MONTH_W) - 1));
      3:       r.year  = '0;
      4:       r.year  = YEAR_W'($urandom_range(int'(YEAR_MAX) + 1, YEAR_TOP));
      default: r = raw[$bits(cal_date_t)-1:0];
    endcase
    return r;
  endfunction

  // second date independent, in the same year, a few years off, or identical
  function automatic in_req_t random_pair();
    cal_date_t a, b;
    int        y;
    int unsigned sel;
    a   = random_date();
    sel = $urandom_range(0, 9);
    if (sel < 4) begin
      b = random_date();
    end else if (sel < 7) begin
      b = random_date();
      b.year = a.year;
    end else if (sel < 9) begin
      b = random_date();
      y = int'(a.year) + int'($urandom_range(0, 6)) - 3;
      if (y < 1) y = 1;
      if (y > int'(YEAR_MAX)) y = int'(YEAR_MAX);
      b.year = YEAR_W'(y);
    end else begin
      b = a;
    end
    if ($urandom_range(0, 9) == 0) a = broken_date(a);
    if ($urandom_range(0, 9) == 0) b = broken_date(b);
    return date_pair(a.day, a.month, a.year, b.day, b.month, b.year);
  endfunction

  // holds a request on the port until the edge that takes it
  task automatic send_request(input in_req_t r);
    start  <= 1'b1;
    in_req <= r;
    do @(posedge clk); while (busy);
  endtask

  // start low for a burst set by n, while the request bus carries junk
  task automatic idle_burst(input int unsigned n);
    logic [63:0] junk;
    start <= 1'b0;
    repeat (n) begin
      junk = {$urandom, $urandom};
      in_req <= junk[$bits(in_req_t)-1:0];
      @(posedge clk);
    end
  endtask

  task automatic hold_until_drained();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    in_req_t     directed_q[$];
    int unsigned waited;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed requests: extremes, leap rules and each kind of invalid date
    directed_q.push_back(date_pair(1, MON_JAN, 1, 1, MON_JAN, 1));
    directed_q.push_back(date_pair(1, MON_JAN, 1, 31, MON_DEC, YEAR_MAX));
    directed_q.push_back(date_pair(31, MON_DEC, YEAR_MAX, 1, MON_JAN, 1));
    directed_q.push_back(date_pair(29, MON_FEB, 2000, 29, MON_FEB, 2400));
    directed_q.push_back(date_pair(29, MON_FEB, 1900, 1, 3, 1900));
    directed_q.push_back(date_pair(29, MON_FEB, 2004, 28, MON_FEB, 2003));
    directed_q.push_back(date_pair(31, MON_DEC, 2000, 1, MON_JAN, 2001));
    directed_q.push_back(date_pair(31, MON_DEC, 2024, 1, MON_JAN, 2024));
    directed_q.push_back(date_pair(0, 5, 2020, 1, 5, 2020));
    directed_q.push_back(date_pair(10, 0, 2020, 10, 6, 2020));
    directed_q.push_back(date_pair(10, 13, 2020, 10, 15, 2020));
    directed_q.push_back(date_pair(31, 4, 2021, 30, MON_FEB, 2024));
    directed_q.push_back(date_pair(31, 6, 1999, 31, 11, 1999));
    directed_q.push_back(date_pair(1, MON_JAN, 0, 1, MON_JAN, 1));
    directed_q.push_back(date_pair(1, MON_JAN, YEAR_MAX + YEAR_W'(1), 5, 5, 5000));
    directed_q.push_back(date_pair(31, 15, YEAR_TOP, 31, 15, YEAR_TOP));
    directed_q.push_back(date_pair(0, 0, 0, 0, 0, 0));
    directed_q.push_back(date_pair(29, MON_FEB, 1600, 1, 3, 1700));
    directed_q.push_back(date_pair(31, 7, 8191, 1, 8, 8192));
    directed_q.push_back(date_pair(28, MON_FEB, 2100, 1, 3, 2100));
    foreach (directed_q[i]) send_request(directed_q[i]);
    hold_until_drained();

    for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 3) hold_until_drained();
      if (i < RANDOM_ITEMS - TAIL_ITEMS && ((i / 64) % 3) != 2 && $urandom_range(0, 3) == 0)
        idle_burst($urandom_range(1, 15));
      send_request(random_pair());
    end

    // wait out the pipeline, then a settling wait for stray strobes
    start <= 1'b0;
    @(posedge clk);
    waited = 0;
    while (pending != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending != 0) $display("%0d results never arrived", pending);
    if (error_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
